>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that prop holds at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that the antecedent is followed in the next cycle by the consequent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants and types of the frame decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int FRAME_BYTES = 23;
  localparam int ADDR_W      = 5;
  localparam int CH_BITS     = 11;
  localparam int CH_IDX_W    = 5;
  localparam int ANALOG_CH   = 16;
  localparam int LAST_CH     = 17;
  localparam int CNT_W       = 5;
  localparam int ACC_W       = 18;
  localparam int DIG0_BIT    = 6;
  localparam int DIG1_BIT    = 7;

  localparam logic [CH_BITS-1:0] FULL_VALUE = 11'h7FF;

  localparam logic CFG_START_BYTE = 1'b0;
  localparam logic CFG_END_BYTE   = 1'b1;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

endpackage

>>> src/sfd_unpack.sv
// ----------------------------------------------------------------------------
// sfd_unpack
// Reads the frame store byte by byte and emits the 18 channel items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfd_unpack
  import sfd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output rd_req_t             rd_req_o,
  input  logic [7:0]          rd_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CH_IDX_W-1:0] channel_index_o,
  output logic [CH_BITS-1:0]  channel_value_o,
  output logic                last_channel_o
);

  typedef enum logic [1:0] {
    U_IDLE,
    U_RUN,
    U_WAIT
  } ustate_e;

  ustate_e             state_q;
  logic [ACC_W-1:0]    acc_q;
  logic [CNT_W-1:0]    nbits_q;
  logic [CH_IDX_W-1:0] ch_q;
  logic [ADDR_W-1:0]   ptr_q;
  logic                out_valid_q;
  logic [CH_IDX_W-1:0] out_idx_q;
  logic [CH_BITS-1:0]  out_val_q;
  logic                out_last_q;

  logic               analog;
  logic               have_bits;
  logic               slot_free;
  logic               emit;
  logic               dig_bit;
  logic [CH_BITS-1:0] ch_value;

  assign analog    = ch_q < CH_IDX_W'(ANALOG_CH);
  assign have_bits = analog ? (nbits_q >= CNT_W'(CH_BITS)) : (nbits_q >= CNT_W'(8));
  assign slot_free = !out_valid_q || out_ready_i;
  assign emit      = (state_q == U_RUN) && have_bits && slot_free;
  assign dig_bit   = ch_q[0] ? acc_q[DIG1_BIT] : acc_q[DIG0_BIT];
  assign ch_value  = analog ? acc_q[CH_BITS-1:0] : (dig_bit ? FULL_VALUE : '0);

  always_comb begin
    rd_req_o.en   = (state_q == U_RUN) && !have_bits;
    rd_req_o.addr = ptr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= U_IDLE;
      acc_q       <= '0;
      nbits_q     <= '0;
      ch_q        <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_val_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        U_IDLE: begin
          if (start_i) begin
            acc_q   <= '0;
            nbits_q <= '0;
            ch_q    <= '0;
            ptr_q   <= '0;
            state_q <= U_RUN;
          end
        end
        U_RUN: begin
          if (have_bits) begin
            if (slot_free) begin
              out_idx_q   <= ch_q;
              out_val_q   <= ch_value;
              out_last_q  <= ch_q == CH_IDX_W'(LAST_CH);
              ch_q        <= ch_q + 1'b1;
              if (analog) begin
                acc_q   <= acc_q >> CH_BITS;
                nbits_q <= nbits_q - CNT_W'(CH_BITS);
              end
              if (ch_q == CH_IDX_W'(LAST_CH)) begin
                state_q <= U_IDLE;
              end
            end
          end else begin
            state_q <= U_WAIT;
          end
        end
        U_WAIT: begin
          acc_q   <= acc_q | (ACC_W'(rd_data_i) << nbits_q);
          nbits_q <= nbits_q + CNT_W'(8);
          ptr_q   <= ptr_q + 1'b1;
          state_q <= U_RUN;
        end
        default: state_q <= U_IDLE;
      endcase
    end
  end

  assign busy_o          = state_q != U_IDLE;
  assign out_valid_o     = out_valid_q;
  assign channel_index_o = out_idx_q;
  assign channel_value_o = out_val_q;
  assign last_channel_o  = out_last_q;

endmodule

>>> src/sbus_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// sbus_frame_decoder_core
// Hunts for the start byte, stores 23 data bytes, checks the end byte and
// emits 16 analog and 2 digital channel items per good frame.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o  data_byte_i
//   out      output     out_valid_o/out_ready_i channel_index_o, channel_value_o,
//                                              last_channel_o
//   cfg      input      cfg_we_i               cfg_addr_i, cfg_wdata_i
//
// A byte other than a good end byte is taken without starting a run.
// A good end byte starts a run of 23 frame store reads (a request, then a
// capture, on one memory port) and 18 output items; out stalls hold it up.
// No input item is taken during that run; the last item may still wait in
// the output register while the next byte is taken.
// Reset clears control state only; the frame store needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbus_frame_decoder_core
  import sfd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CH_IDX_W-1:0] channel_index_o,
  output logic [CH_BITS-1:0]  channel_value_o,
  output logic                last_channel_o,
  input  logic                cfg_we_i,
  input  logic                cfg_addr_i,
  input  logic [7:0]          cfg_wdata_i
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_COLLECT,
    PH_CHECK
  } phase_e;

  phase_e            phase_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [7:0]        start_byte_q;
  logic [7:0]        end_byte_q;
  logic [7:0]        store_q [FRAME_BYTES];
  logic [7:0]        rd_data_q;

  logic    in_fire;
  logic    start_emit;
  logic    busy;
  rd_req_t rd_req;

  assign in_ready_o = !busy;
  assign in_fire    = in_valid_i && in_ready_o;
  assign start_emit = in_fire && (phase_q == PH_CHECK) && (data_byte_i == end_byte_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= 8'd15;
      end_byte_q   <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_START_BYTE: start_byte_q <= cfg_wdata_i;
        CFG_END_BYTE:   end_byte_q   <= cfg_wdata_i;
        default:        start_byte_q <= start_byte_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cnt_q   <= '0;
    end else if (in_fire) begin
      unique case (phase_q)
        PH_COLLECT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(FRAME_BYTES - 1)) begin
            phase_q <= PH_CHECK;
          end
        end
        PH_CHECK: begin
          phase_q <= PH_HUNT;
          cnt_q   <= '0;
        end
        default: begin
          if (data_byte_i == start_byte_q) begin
            phase_q <= PH_COLLECT;
            cnt_q   <= '0;
          end else begin
            phase_q <= PH_HUNT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && (phase_q == PH_COLLECT)) begin
      store_q[cnt_q] <= data_byte_i;
    end
    if (rd_req.en) begin
      rd_data_q <= store_q[rd_req.addr];
    end
  end

  sfd_unpack u_unpack (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_emit),
    .busy_o          (busy),
    .rd_req_o        (rd_req),
    .rd_data_i       (rd_data_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .last_channel_o  (last_channel_o)
  );

  `ASSERT_CLK(a_rd_no_write, !(rd_req.en && in_fire), "store read overlaps a write")
  `ASSERT_CLK(a_cnt_range, (phase_q != PH_COLLECT) || (cnt_q < CNT_W'(FRAME_BYTES)),
              "byte count past frame")
  `ASSERT_CLK(a_last_idx, !(out_valid_o && last_channel_o) ||
              (channel_index_o == CH_IDX_W'(LAST_CH)), "last flag on wrong channel")
  `ASSERT_NEXT(a_emit_busy, start_emit, busy && (phase_q == PH_HUNT),
               "emission did not start")

endmodule
